/* src/tlws_pkg.sv */
// Package for the two-level weighted sampler: request codes, datapath
// command and status structs, controller states, compare helper.
// No dependencies.
`default_nettype none
package tlws_pkg;

	localparam int TW = 48;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_CHOOSE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CLR,
		OP_LOAD,
		OP_MUL,
		OP_IP,
		OP_PSTEP,
		OP_ESTART,
		OP_ESTEP,
		OP_EFIN,
		OP_DIV,
		OP_WUPD
	} op_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_CHOOSE,
		OUT_READ,
		OUT_BAD
	} out_sel_t;

	typedef struct packed {
		op_t      op;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic arr_ok;
		logic elem_ok;
		logic p_more;
		logic w_more;
		logic e_more;
		logic w_zero;
		logic diff_big;
		logic div_last;
		logic clr_last;
	} sts_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WFIND,
		S_WWAIT,
		S_WUPD,
		S_RWAIT,
		S_MUL,
		S_IP,
		S_PWAIT,
		S_PCHK,
		S_EWAIT,
		S_ECHK,
		S_DIV,
		S_OUT_CH,
		S_OUT_RD,
		S_OUT_BAD
	} state_t;

	// s < ip + fr / 2^32
	function automatic logic below(input logic [TW-1:0] s, input logic [TW-1:0] ip,
		input logic [31:0] fr);
		return (s < ip) || ((s == ip) && (fr != 32'd0));
	endfunction

endpackage
`default_nettype wire

/* src/tlws_ctrl.sv */
// Controller state machine for the two-level weighted sampler.
// Depends on tlws_pkg; drives tlws_dp through cmd_t, reads sts_t.
`default_nettype none
module tlws_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      req_type,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  tlws_pkg::sts_t       sts,
	output tlws_pkg::cmd_t       cmd
);
	import tlws_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (cmd.out_sel != OUT_NONE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					unique case (req_type)
						REQ_WRITE:  state_d = (sts.arr_ok && sts.elem_ok) ? S_WFIND : S_IDLE;
						REQ_CHOOSE: state_d = sts.arr_ok ? S_MUL : S_OUT_BAD;
						REQ_READ:   state_d = S_RWAIT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_WFIND: if (!sts.w_more) state_d = S_WWAIT;
			S_WWAIT: state_d = S_WUPD;
			S_WUPD:  state_d = S_IDLE;
			S_RWAIT: state_d = S_OUT_RD;
			S_MUL:   state_d = S_IP;
			S_IP:    state_d = S_PWAIT;
			S_PWAIT: state_d = S_PCHK;
			S_PCHK:  state_d = sts.p_more ? S_PWAIT : S_EWAIT;
			S_EWAIT: state_d = S_ECHK;
			S_ECHK: begin
				if (sts.e_more) state_d = S_EWAIT;
				else if (sts.w_zero || sts.diff_big) state_d = S_OUT_CH;
				else state_d = S_DIV;
			end
			S_DIV:     if (sts.div_last) state_d = S_OUT_CH;
			S_OUT_CH,
			S_OUT_RD,
			S_OUT_BAD: if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = OP_IDLE;
		cmd.out_sel = OUT_NONE;
		unique case (state_q)
			S_CLEAR: cmd.op = OP_CLR;
			S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
			S_WFIND: if (sts.w_more) cmd.op = OP_PSTEP;
			S_WUPD:  cmd.op = OP_WUPD;
			S_MUL:   cmd.op = OP_MUL;
			S_IP:    cmd.op = OP_IP;
			S_PCHK:  cmd.op = sts.p_more ? OP_PSTEP : OP_ESTART;
			S_ECHK:  cmd.op = sts.e_more ? OP_ESTEP : OP_EFIN;
			S_DIV:   cmd.op = OP_DIV;
			S_OUT_CH:  if (out_free) cmd.out_sel = OUT_CHOOSE;
			S_OUT_RD:  if (out_free) cmd.out_sel = OUT_READ;
			S_OUT_BAD: if (out_free) cmd.out_sel = OUT_BAD;
			default: cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !sts.div_last) |=> (state_q == S_DIV))
		else $error("divider left early");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result word lost");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!out_valid_q && !in_ready))
		else $error("activity during clearing pass");

endmodule
`default_nettype wire

/* src/tlws_dp.sv */
// Datapath for the two-level weighted sampler: weight, part-sum and
// root-sum memories, scan registers, multiplier, radix-2 divider, output.
// Depends on tlws_pkg; driven by tlws_ctrl.
`default_nettype none
module tlws_dp #(
	parameter int NUM_ARRAYS = 16,
	parameter int ARRAY_SIZE = 64,
	parameter int NUM_PARTS  = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tlws_pkg::cmd_t     cmd,
	output tlws_pkg::sts_t     sts,
	input  wire logic [3:0]    array_sel,
	input  wire logic [5:0]    element_sel,
	input  wire logic [31:0]   weight_value,
	input  wire logic [31:0]   random_fraction,
	input  wire logic [39:0]   scale_total,
	output logic [5:0]         chosen_index,
	output logic [31:0]        leftover_fraction,
	output logic [39:0]        array_total,
	output logic               overrun_flag
);
	import tlws_pkg::*;

	localparam int WD  = NUM_ARRAYS * ARRAY_SIZE;
	localparam int PD  = NUM_ARRAYS * NUM_PARTS;
	localparam int RD  = NUM_ARRAYS;
	localparam int CD  = (WD > PD) ? WD : PD;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
	localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
	localparam int CLW = (CD > 1) ? $clog2(CD) : 1;
	localparam int EW  = $clog2(ARRAY_SIZE);
	localparam int SW  = $clog2(ARRAY_SIZE + 1);
	localparam int PW  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int PR  = ARRAY_SIZE / NUM_PARTS;
	localparam int PC  = ARRAY_SIZE % NUM_PARTS;
	localparam int PL  = PR + ((PC > 0) ? 1 : 0);

	logic [31:0] wmem [WD];
	logic [39:0] pmem [PD];
	logic [39:0] rmem [RD];

	logic [RAW-1:0] a_q;
	logic [EW-1:0]  e_q;
	logic [31:0]    wv_q, rf_q;
	logic [39:0]    st_q;
	logic [WAW-1:0] abase_q;
	logic [PAW-1:0] pbase_q;
	logic           arr_ok_q;
	logic [63:0]    lo_q;
	logic [39:0]    hi_q;
	logic [40:0]    ip_q;
	logic [31:0]    fr_q;
	logic [TW-1:0]  total_q;
	logic [PW-1:0]  p_q;
	logic [SW-1:0]  start_q;
	logic [31:0]    w_q;
	logic           zero_q, big_q, flag_q;
	logic [31:0]    rem_q, quo_q;
	logic [4:0]     div_cnt_q;
	logic [CLW-1:0] clr_cnt_q;
	logic [31:0]    ws_rd_q;
	logic [39:0]    ps_rd_q, rt_rd_q;

	logic [WAW-1:0] waddr;
	logic [PAW-1:0] paddr;
	logic [SW-1:0]  psize;
	logic [TW-1:0]  ip_ext, p_sum, e_sum, diff;
	logic           p_last, e_last;
	logic [32:0]    dtry;
	logic           dge;
	logic           clr, wupd;

	assign waddr  = abase_q + WAW'(e_q);
	assign paddr  = pbase_q + PAW'(p_q);
	assign psize  = (32'(p_q) < PC) ? SW'(PL) : SW'(PR);
	assign ip_ext = TW'(ip_q);
	assign p_sum  = total_q + TW'(ps_rd_q);
	assign e_sum  = total_q + TW'(ws_rd_q);
	assign p_last = (32'(p_q) + 1 >= NUM_PARTS);
	assign e_last = (32'(e_q) + 1 >= ARRAY_SIZE);
	assign diff   = (ip_ext >= total_q) ? (ip_ext - total_q) : '0;
	assign dtry   = {rem_q, quo_q[31]};
	assign dge    = (dtry >= {1'b0, w_q});
	assign clr    = (cmd.op == OP_CLR);
	assign wupd   = (cmd.op == OP_WUPD);

	always_comb begin
		sts.arr_ok   = (32'(array_sel) < NUM_ARRAYS);
		sts.elem_ok  = (32'(element_sel) < ARRAY_SIZE);
		sts.p_more   = !p_last && below(p_sum, ip_ext, fr_q);
		sts.w_more   = !p_last &&
			((SW+1)'(e_q) >= ((SW+1)'(start_q) + (SW+1)'(psize)));
		sts.e_more   = !e_last && below(e_sum, ip_ext, fr_q);
		sts.w_zero   = (ws_rd_q == 32'd0);
		sts.diff_big = (diff >= TW'(ws_rd_q));
		sts.div_last = (div_cnt_q == 5'd31);
		sts.clr_last = (32'(clr_cnt_q) == CD - 1);
	end

	always_ff @(posedge clk) begin
		ws_rd_q <= wmem[waddr];
		if (clr && (32'(clr_cnt_q) < WD)) wmem[clr_cnt_q[WAW-1:0]] <= 32'd0;
		else if (wupd) wmem[waddr] <= wv_q;
	end

	always_ff @(posedge clk) begin
		ps_rd_q <= pmem[paddr];
		if (clr && (32'(clr_cnt_q) < PD)) pmem[clr_cnt_q[PAW-1:0]] <= 40'd0;
		else if (wupd) pmem[paddr] <= 40'(ps_rd_q + 40'(wv_q) - 40'(ws_rd_q));
	end

	always_ff @(posedge clk) begin
		rt_rd_q <= rmem[a_q];
		if (clr && (32'(clr_cnt_q) < RD)) rmem[clr_cnt_q[RAW-1:0]] <= 40'd0;
		else if (wupd) rmem[a_q] <= 40'(rt_rd_q + 40'(wv_q) - 40'(ws_rd_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (clr) clr_cnt_q <= clr_cnt_q + CLW'(1);
			if (cmd.op == OP_EFIN) div_cnt_q <= '0;
			else if (cmd.op == OP_DIV) div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				a_q      <= RAW'(array_sel);
				e_q      <= EW'(element_sel);
				wv_q     <= weight_value;
				rf_q     <= random_fraction;
				st_q     <= scale_total;
				abase_q  <= WAW'(RAW'(array_sel)) * WAW'(ARRAY_SIZE);
				pbase_q  <= PAW'(RAW'(array_sel)) * PAW'(NUM_PARTS);
				arr_ok_q <= (32'(array_sel) < NUM_ARRAYS);
				total_q  <= '0;
				p_q      <= '0;
				start_q  <= '0;
			end
			OP_MUL: begin
				lo_q <= 64'(rf_q) * 64'(st_q[31:0]);
				hi_q <= 40'(rf_q) * 40'(st_q[39:32]);
			end
			OP_IP: begin
				ip_q <= 41'(lo_q[63:32]) + 41'(hi_q);
				fr_q <= lo_q[31:0];
			end
			OP_PSTEP: begin
				total_q <= p_sum;
				p_q     <= p_q + PW'(1);
				start_q <= start_q + psize;
			end
			OP_ESTART: e_q <= (start_q >= SW'(ARRAY_SIZE)) ? EW'(ARRAY_SIZE - 1) :
				start_q[EW-1:0];
			OP_ESTEP: begin
				total_q <= e_sum;
				e_q     <= e_q + EW'(1);
			end
			OP_EFIN: begin
				w_q    <= ws_rd_q;
				zero_q <= sts.w_zero;
				big_q  <= sts.diff_big;
				flag_q <= below(e_sum, ip_ext, fr_q) || sts.w_zero;
				rem_q  <= diff[31:0];
				quo_q  <= fr_q;
			end
			OP_DIV: begin
				rem_q <= dge ? 32'(dtry - {1'b0, w_q}) : dtry[31:0];
				quo_q <= {quo_q[30:0], dge};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.out_sel)
			OUT_CHOOSE: begin
				chosen_index      <= 6'(e_q);
				leftover_fraction <= zero_q ? 32'd0 : (big_q ? 32'hFFFF_FFFF : quo_q);
				array_total       <= 40'd0;
				overrun_flag      <= flag_q;
			end
			OUT_READ: begin
				chosen_index      <= 6'd0;
				leftover_fraction <= 32'd0;
				array_total       <= arr_ok_q ? rt_rd_q : 40'd0;
				overrun_flag      <= 1'b0;
			end
			OUT_BAD: begin
				chosen_index      <= 6'd0;
				leftover_fraction <= 32'd0;
				array_total       <= 40'd0;
				overrun_flag      <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* src/two_level_weighted_sampler_unit.sv */
// Write: a part scan finds the element's part, then weight, part and root sums update.
// Read: root-sum read, then output. Choose: multiply, integer part, part scan, element
// scan, then the radix-2 divider unless the weight is zero or the difference reaches it.
// One word in flight: in_ready is high only in idle. Reset: controller state and
// counters clear; a clearing pass zeroes the memories, with in_ready low until it ends.
`default_nettype none
module two_level_weighted_sampler_unit #(
	parameter int NUM_ARRAYS = 16,
	parameter int ARRAY_SIZE = 64,
	parameter int NUM_PARTS  = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   req_type,
	input  wire logic [3:0]   array_sel,
	input  wire logic [5:0]   element_sel,
	input  wire logic [31:0]  weight_value,
	input  wire logic [31:0]  random_fraction,
	input  wire logic [39:0]  scale_total,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [5:0]        chosen_index,
	output logic [31:0]       leftover_fraction,
	output logic [39:0]       array_total,
	output logic              overrun_flag
);
	import tlws_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tlws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlws_dp #(
		.NUM_ARRAYS (NUM_ARRAYS),
		.ARRAY_SIZE (ARRAY_SIZE),
		.NUM_PARTS  (NUM_PARTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.array_sel         (array_sel),
		.element_sel       (element_sel),
		.weight_value      (weight_value),
		.random_fraction   (random_fraction),
		.scale_total       (scale_total),
		.chosen_index      (chosen_index),
		.leftover_fraction (leftover_fraction),
		.array_total       (array_total),
		.overrun_flag      (overrun_flag)
	);

endmodule
`default_nettype wire
